/* hdl/che_pkg.sv */
// Shared types, widths and register codes for the cubic Hermite segment evaluator.
package che_pkg;

  localparam int S_W       = 18;
  localparam int REG_W     = 32;
  localparam int VAL_W     = 42;
  localparam int OUT_W     = 40;
  localparam int FRAC      = 16;
  localparam int PROD_W    = S_W + VAL_W;
  localparam int NUM_CELLS = 3;
  localparam int IDX_W     = 3;

  typedef logic signed [S_W-1:0]    param_t;
  typedef logic signed [REG_W-1:0]  reg_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  typedef struct packed {
    val_t pos;
    val_t d1;
    val_t d2;
  } lanes_t;

  typedef struct packed {
    param_t s;
    lanes_t acc;
  } beat_t;

  typedef lanes_t [NUM_CELLS-1:0] coef_row_t;

  typedef enum logic [IDX_W-1:0] {
    REG_START_POSITION = 3'd0,
    REG_START_VELOCITY = 3'd1,
    REG_END_POSITION   = 3'd2,
    REG_END_VELOCITY   = 3'd3,
    REG_CLAMP_LOW      = 3'd4,
    REG_CLAMP_HIGH     = 3'd5
  } reg_index_t;

  localparam param_t CLAMP_HIGH_RESET = param_t'(1 << FRAC);
  localparam prod_t  ROUND_HALF       = prod_t'(1 << (FRAC - 1));

  localparam val_t OUT_MAX = val_t'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam val_t OUT_MIN = val_t'(-(64'sd1 <<< (OUT_W - 1)));

  function automatic out_t sat_out(input val_t v);
    out_t r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/che_cfg.sv */
// Configuration registers and the registered Horner coefficients for each cell.
module che_cfg import che_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output param_t               clamp_low,
  output param_t               clamp_high,
  output lanes_t               init_acc,
  output coef_row_t            cell_coef
);

  reg_t p1, v1, p2, v2;
  val_t p1x, v1x, p2x, v2x, dp, c3_next, c2_next;
  val_t c3, c2, p1_d, v1_d, x3;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1         <= '0;
      v1         <= '0;
      p2         <= '0;
      v2         <= '0;
      clamp_low  <= '0;
      clamp_high <= CLAMP_HIGH_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_START_POSITION: p1 <= reg_t'(cfg_data);
        REG_START_VELOCITY: v1 <= reg_t'(cfg_data);
        REG_END_POSITION:   p2 <= reg_t'(cfg_data);
        REG_END_VELOCITY:   v2 <= reg_t'(cfg_data);
        REG_CLAMP_LOW:      clamp_low <= param_t'(cfg_data[S_W-1:0]);
        REG_CLAMP_HIGH:     clamp_high <= param_t'(cfg_data[S_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    p1x     = val_t'(p1);
    v1x     = val_t'(v1);
    p2x     = val_t'(p2);
    v2x     = val_t'(v2);
    dp      = p2x - p1x;
    c3_next = v1x + v2x - (dp <<< 1);
    c2_next = dp + (dp <<< 1) - (v1x <<< 1) - v2x;
  end

  // two coefficient stages; init_acc is registered straight from c3_next
  always_ff @(posedge clk) begin
    if (rst) begin
      c3       <= '0;
      c2       <= '0;
      p1_d     <= '0;
      v1_d     <= '0;
      init_acc <= '0;
      cell_coef <= '0;
    end else begin
      c3   <= c3_next;
      c2   <= c2_next;
      p1_d <= p1x;
      v1_d <= v1x;
      init_acc     <= '{pos: c3_next, d1: '0, d2: '0};
      cell_coef[0] <= '{pos: c2, d1: x3, d2: '0};
      cell_coef[1] <= '{pos: v1_d, d1: c2 <<< 1, d2: x3 <<< 1};
      cell_coef[2] <= '{pos: p1_d, d1: v1_d, d2: c2 <<< 1};
    end
  end

  assign x3 = c3 + (c3 <<< 1);

endmodule

/* hdl/che_cell.sv */
// One Horner cell: acc = coef + round(s * acc) on three lanes, two register stages.
module che_cell import che_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  lanes_t coef,
  input  logic   up_valid,
  output logic   up_ready,
  input  beat_t  up_beat,
  output logic   dn_valid,
  input  logic   dn_ready,
  output beat_t  dn_beat
);

  logic   a_valid, a_ready, b_ready;
  param_t a_s;
  prod_t  a_pos, a_d1, a_d2;
  prod_t  r_pos, r_d1, r_d2;

  assign b_ready  = !dn_valid || dn_ready;
  assign a_ready  = !a_valid || b_ready;
  assign up_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_ready) begin
      a_s   <= up_beat.s;
      a_pos <= up_beat.s * up_beat.acc.pos;
      a_d1  <= up_beat.s * up_beat.acc.d1;
      a_d2  <= up_beat.s * up_beat.acc.d2;
    end
  end

  assign r_pos = a_pos + ROUND_HALF;
  assign r_d1  = a_d1 + ROUND_HALF;
  assign r_d2  = a_d2 + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (b_ready) begin
      dn_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_ready) begin
      dn_beat.s       <= a_s;
      dn_beat.acc.pos <= coef.pos + val_t'(r_pos[FRAC+VAL_W-1:FRAC]);
      dn_beat.acc.d1  <= coef.d1 + val_t'(r_d1[FRAC+VAL_W-1:FRAC]);
      dn_beat.acc.d2  <= coef.d2 + val_t'(r_d2[FRAC+VAL_W-1:FRAC]);
    end
  end

endmodule

/* hdl/cubic_hermite_segment_eval_core.sv */
// Top level of the cubic Hermite segment evaluator: clamp stage, cell row, output stage.
//
// Input channel: curve_param (Q2.16) with in_valid/in_ready. Output channel:
// position, first_derivative, second_derivative (Q24.16, saturated) with
// out_valid/out_ready, one result beat per input beat, in order.
// Configuration: cfg_write with cfg_index and cfg_data, taken in the same cycle;
// the four Hermite inputs feed two coefficient register stages (init_acc only the
// first), so beats in flight at a write may mix old and new coefficients.
// Path: the clamp stage, three cells of two stages each, then the output
// register. Throughput: one beat per cycle while out_ready does not stall
// the output; each cell has three 18x42 multipliers, one per lane.
// Every stage has its own valid bit and holds only when the next is full and
// stalled, so bubbles close up and input is still taken while a result waits.
// If out_ready stays low the row fills and in_ready drops after eight beats.
// Reset (rst, synchronous) empties the pipeline and restores the register
// reset values: zero Hermite inputs, clamp bounds 0 and 1.0.
module cubic_hermite_segment_eval_core import che_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  param_t           curve_param,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             position,
  output out_t             first_derivative,
  output out_t             second_derivative
);

  param_t    clamp_low, clamp_high, s_next;
  lanes_t    init_acc;
  coef_row_t cell_coef;

  logic  s0_valid;
  param_t s0_s;
  logic  chain_valid [NUM_CELLS+1];
  logic  chain_ready [NUM_CELLS+1];
  beat_t chain_beat  [NUM_CELLS+1];
  logic  out_load;

  che_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clamp_low  (clamp_low),
    .clamp_high (clamp_high),
    .init_acc   (init_acc),
    .cell_coef  (cell_coef)
  );

  always_comb begin
    if (curve_param < clamp_low) begin
      s_next = clamp_low;
    end else if (curve_param > clamp_high) begin
      s_next = clamp_high;
    end else begin
      s_next = curve_param;
    end
  end

  assign in_ready = !s0_valid || chain_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_s <= s_next;
    end
  end

  assign chain_valid[0] = s0_valid;
  assign chain_beat[0]  = '{s: s0_s, acc: init_acc};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    che_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .coef     (cell_coef[i]),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_beat  (chain_beat[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_beat  (chain_beat[i+1])
    );
  end

  assign chain_ready[NUM_CELLS] = !out_valid || out_ready;
  assign out_load = chain_valid[NUM_CELLS] && chain_ready[NUM_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (chain_ready[NUM_CELLS]) begin
      out_valid <= chain_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      position          <= sat_out(chain_beat[NUM_CELLS].acc.pos);
      first_derivative  <= sat_out(chain_beat[NUM_CELLS].acc.d1);
      second_derivative <= sat_out(chain_beat[NUM_CELLS].acc.d2);
    end
  end

`ifndef SYNTHESIS
  a_empty_front_ready: assert property (@(posedge clk) disable iff (rst)
    !s0_valid |-> in_ready)
    else $error("input not ready with empty clamp stage");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s0_valid)
    else $error("accepted beat missing from clamp stage");

  a_reset_empties: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s0_valid)
    else $error("pipeline not empty after reset");

  a_out_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> chain_ready[NUM_CELLS])
    else $error("empty output stage refuses cell row");
`endif

endmodule

/* verif/cubic_hermite_segment_eval_core_tb.sv */
// Self-checking testbench for the cubic Hermite segment evaluator: directed table, then random traffic.
module cubic_hermite_segment_eval_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import che_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS_PER_PHASE = 4;
  localparam int BEATS_PER_SEGMENT = 57;
  localparam int LONG_HOLD_CYCLES = 300;

  localparam logic [IDX_W-1:0] IDX_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_7 = 3'd7;

  localparam logic [REG_W-1:0] R32_MAX = 32'h7FFF_FFFF;
  localparam logic [REG_W-1:0] R32_MIN = 32'h8000_0000;
  localparam param_t S_MIN  = 18'sh20000;
  localparam param_t S_MAX  = 18'sh1FFFF;
  localparam param_t S_ONE  = 18'sh10000;
  localparam param_t S_HALF = 18'sh08000;

  localparam longint OUT_HI = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam longint OUT_LO = -(64'sd1 <<< (OUT_W - 1));

  typedef struct {
    out_t pos;
    out_t d1;
    out_t d2;
  } curve_sample_t;

  typedef struct {
    bit               is_cfg;
    logic [IDX_W-1:0] idx;
    logic [REG_W-1:0] data;
    param_t           s;
    bit               typed;
    curve_sample_t    want;
  } stim_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  param_t           curve_param;
  logic             out_valid;
  logic             out_ready;
  out_t             position;
  out_t             first_derivative;
  out_t             second_derivative;

  // shadow copy of the segment registers
  longint seg_p1, seg_v1, seg_p2, seg_v2;
  longint clamp_lo, clamp_hi;

  curve_sample_t pending_samples[$];
  stim_row_t     plan[$];

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  cubic_hermite_segment_eval_core dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .curve_param       (curve_param),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .position          (position),
    .first_derivative  (first_derivative),
    .second_derivative (second_derivative)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint scale_round(longint s, longint t);
    return (s * t + 64'sd32768) >>> FRAC;
  endfunction

  function automatic out_t clip40(longint v);
    longint c;
    c = v;
    if (c > OUT_HI) c = OUT_HI;
    if (c < OUT_LO) c = OUT_LO;
    return c[OUT_W-1:0];
  endfunction

  function automatic curve_sample_t predict_sample(param_t s_raw);
    longint s, c3, c2, t, pos, d1, d2;
    curve_sample_t r;
    s = longint'(s_raw);
    if (s < clamp_lo) s = clamp_lo;
    else if (s > clamp_hi) s = clamp_hi;
    c3 = 2 * (seg_p1 - seg_p2) + seg_v1 + seg_v2;
    c2 = 3 * (seg_p2 - seg_p1) - 2 * seg_v1 - seg_v2;
    t = c2 + scale_round(s, c3);
    t = seg_v1 + scale_round(s, t);
    pos = seg_p1 + scale_round(s, t);
    t = 2 * c2 + scale_round(s, 3 * c3);
    d1 = seg_v1 + scale_round(s, t);
    d2 = 2 * c2 + scale_round(s, 6 * c3);
    r.pos = clip40(pos);
    r.d1 = clip40(d1);
    r.d2 = clip40(d2);
    return r;
  endfunction

  function automatic void note_write(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    case (idx)
      REG_START_POSITION: seg_p1 = longint'($signed(data));
      REG_START_VELOCITY: seg_v1 = longint'($signed(data));
      REG_END_POSITION:   seg_p2 = longint'($signed(data));
      REG_END_VELOCITY:   seg_v2 = longint'($signed(data));
      REG_CLAMP_LOW:      clamp_lo = longint'($signed(data[S_W-1:0]));
      REG_CLAMP_HIGH:     clamp_hi = longint'($signed(data[S_W-1:0]));
      default: ;
    endcase
  endfunction

  function automatic void add_write(logic [IDX_W-1:0] idx, logic [REG_W-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic void add_beat(param_t s);
    stim_row_t r;
    r = '{default: '0};
    r.s = s;
    plan.push_back(r);
  endfunction

  function automatic void add_known(param_t s, out_t pos, out_t d1, out_t d2);
    stim_row_t r;
    r = '{default: '0};
    r.s = s;
    r.typed = 1'b1;
    r.want = '{pos, d1, d2};
    plan.push_back(r);
  endfunction

  function automatic logic [REG_W-1:0] pick_reg32();
    logic [REG_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = R32_MAX;
      1: v = R32_MIN;
      2: v = '0;
      3: v = REG_W'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [S_W-1:0] pick_bound();
    logic [S_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = S_MIN;
      1: v = S_MAX;
      2: v = '0;
      3: v = S_ONE;
      default: v = S_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic param_t pick_param();
    param_t s;
    case ($urandom_range(0, 9))
      0: s = S_MIN;
      1: s = S_MAX;
      2: s = param_t'(clamp_lo + longint'($urandom_range(0, 4)) - 2);
      3: s = param_t'(clamp_hi + longint'($urandom_range(0, 4)) - 2);
      4, 5: begin
        if (clamp_hi > clamp_lo) begin
          s = param_t'(clamp_lo + longint'($urandom_range(0, int'(clamp_hi - clamp_lo))));
        end else begin
          s = param_t'($urandom);
        end
      end
      default: s = param_t'($urandom);
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    note_write(idx, data);
    @(posedge clk);
  endtask

  task automatic send_param(input param_t s, input curve_sample_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    curve_param <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_samples.push_back(want);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_samples.size() != 0);
  endtask

  task automatic randomize_segment();
    logic [S_W-1:0]   lo_b, hi_b, tmp_b;
    logic [REG_W-1:0] junk;
    write_reg(REG_START_POSITION, pick_reg32());
    write_reg(REG_START_VELOCITY, pick_reg32());
    write_reg(REG_END_POSITION, pick_reg32());
    write_reg(REG_END_VELOCITY, pick_reg32());
    lo_b = pick_bound();
    hi_b = pick_bound();
    if ($urandom_range(0, 9) < 7 && $signed(lo_b) > $signed(hi_b)) begin
      tmp_b = lo_b;
      lo_b = hi_b;
      hi_b = tmp_b;
    end
    junk = $urandom;
    write_reg(REG_CLAMP_LOW, {junk[REG_W-1:S_W], lo_b});
    junk = $urandom;
    write_reg(REG_CLAMP_HIGH, {junk[REG_W-1:S_W], hi_b});
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? IDX_SPARE_6 : IDX_SPARE_7, $urandom);
    end
    cfg_write <= 1'b0;
  endtask

  // receiver side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    curve_sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result beat: pos %0d d1 %0d d2 %0d",
                   position, first_derivative, second_derivative);
        end
      end else begin
        want = pending_samples.pop_front();
        if (want.pos !== position || want.d1 !== first_derivative ||
            want.d2 !== second_derivative) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: pos exp %0d got %0d, d1 exp %0d got %0d, d2 exp %0d got %0d",
                     want.pos, position, want.d1, first_derivative,
                     want.d2, second_derivative);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cubic_hermite_segment_eval_core verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    bit            in_cfg;
    curve_sample_t want;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    curve_param = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    hold_left = 0;
    send_idle_pct = 13;
    recv_idle_pct = 66;
    seg_p1 = 0;
    seg_v1 = 0;
    seg_p2 = 0;
    seg_v2 = 0;
    clamp_lo = 0;
    clamp_hi = 65536;
    in_cfg = 1'b0;

    // reset values: flat zero segment
    add_known(S_MIN, '0, '0, '0);
    add_known(S_MAX, '0, '0, '0);
    add_known('0, '0, '0, '0);
    add_known(S_ONE, '0, '0, '0);
    // constant segment at the register extremes
    add_write(REG_START_POSITION, R32_MAX);
    add_write(REG_END_POSITION, R32_MAX);
    add_known(S_MAX, out_t'(64'sh7FFF_FFFF), '0, '0);
    add_known(S_MIN, out_t'(64'sh7FFF_FFFF), '0, '0);
    add_write(REG_START_POSITION, R32_MIN);
    add_write(REG_END_POSITION, R32_MIN);
    add_known(S_HALF, out_t'(-64'sh8000_0000), '0, '0);
    // steep tangents
    add_write(REG_START_POSITION, '0);
    add_write(REG_END_POSITION, '0);
    add_write(REG_START_VELOCITY, R32_MAX);
    add_write(REG_END_VELOCITY, R32_MAX);
    add_beat(S_ONE);
    add_beat('0);
    add_beat(S_MAX);
    add_beat(S_HALF);
    // widest bounds
    add_write(REG_CLAMP_LOW, REG_W'(S_MIN));
    add_write(REG_CLAMP_HIGH, REG_W'(S_MAX));
    add_beat(S_MIN);
    add_beat(S_MAX);
    add_beat(param_t'(-1));
    add_write(REG_START_POSITION, R32_MAX);
    add_write(REG_END_POSITION, R32_MIN);
    add_beat(S_MIN);
    add_beat(S_MAX);
    // crossed bounds
    add_write(REG_CLAMP_LOW, REG_W'(S_ONE));
    add_write(REG_CLAMP_HIGH, '0);
    add_beat(param_t'(-5));
    add_beat(param_t'(100));
    add_beat(S_MAX);
    // writes to unused indexes are dropped
    add_write(IDX_SPARE_6, $urandom);
    add_write(IDX_SPARE_7, $urandom);
    add_beat(param_t'(12345));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_cfg) wait_drain();
        write_reg(plan[i].idx, plan[i].data);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) begin
          cfg_write <= 1'b0;
          in_cfg = 1'b0;
        end
        want = plan[i].typed ? plan[i].want : predict_sample(plan[i].s);
        send_param(plan[i].s, want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 13; recv_idle_pct = 66; end
        1: begin send_idle_pct = 66; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
        param_t s;
        wait_drain();
        randomize_segment();
        if (phase == 2 && seg == 1) hold_left = LONG_HOLD_CYCLES;
        for (int n = 0; n < BEATS_PER_SEGMENT; n++) begin
          s = pick_param();
          send_param(s, predict_sample(s));
        end
      end
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("cubic_hermite_segment_eval_core verification clean");
    end else begin
      $display("cubic_hermite_segment_eval_core verification failed");
    end
    $finish;
  end

endmodule
